/* rtl/cle_pkg.sv */
// Shared types and constants of the console line editor.
// Used by every module of the block but cle_ram; depends on nothing.
package cle_pkg;

  // Default ring depth and result fan-out of one received word
  localparam int unsigned RING_DEPTH_DEF = 128;
  localparam int unsigned MAX_RES        = 4;
  localparam int unsigned CNT_W          = $clog2(MAX_RES + 1);

  // Control and special characters
  localparam logic [7:0] KEY_NUL    = 8'h00;
  localparam logic [7:0] KEY_CTRL_C = 8'h03;
  localparam logic [7:0] KEY_CTRL_D = 8'h04;
  localparam logic [7:0] KEY_CTRL_H = 8'h08;
  localparam logic [7:0] KEY_LF     = 8'h0a;
  localparam logic [7:0] KEY_CR     = 8'h0d;
  localparam logic [7:0] KEY_CTRL_U = 8'h15;
  localparam logic [7:0] KEY_DEL    = 8'h7f;
  localparam logic [7:0] KEY_CARET  = 8'h5e;
  localparam logic [7:0] KEY_UPPER_C = 8'h43;

  // Input opcodes
  localparam logic OP_RX   = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_ECHO     = 3'd0,
    KIND_ERASE    = 3'd1,
    KIND_READ     = 3'd2,
    KIND_EMPTY    = 3'd3,
    KIND_EOF      = 3'd4,
    KIND_EOF_STOP = 3'd5
  } kind_e;

  // One input word
  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_char;
    logic       first_of_read;
  } item_t;

  // One result word
  typedef struct packed {
    kind_e      kind;
    logic [7:0] value;
    logic [7:0] erase_count;
    logic       line_committed;
    logic       last;
  } result_t;

  // All results of one input word, entry 0 goes out first
  typedef struct packed {
    logic [CNT_W-1:0]          cnt;
    result_t [MAX_RES-1:0]     res;
  } res_bundle_t;

endpackage

/* rtl/console_line_editor.sv */
// Console line editor: an accepted word is decoded in the cycle after it is taken;
// its results go into the result queue once it is free and show from the cycle after.
// A word has 1 to 4 results or none, and one with none never waits for the queue;
// one word per cycle at best, as long as the single result port does not stall.
// Reset clears the ring pointers and the queue; ring contents are left as they are,
// no clearing pass.
module console_line_editor #(
  parameter int unsigned RING_DEPTH = cle_pkg::RING_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       opcode_i,
  input  logic [7:0] rx_char_i,
  input  logic       first_of_read_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] kind_o,
  output logic [7:0] value_o,
  output logic [7:0] erase_count_o,
  output logic       line_committed_o,
  output logic       last_o
);

  cle_pkg::item_t       item_q;
  logic                 item_vld_q, item_vld_d;
  logic                 accept, fire, load, free;
  cle_pkg::res_bundle_t bundle;
  cle_pkg::result_t     head;

  // Input register handshake
  assign fire       = item_vld_q && ((bundle.cnt == '0) || free);
  assign load       = fire && (bundle.cnt != '0);
  assign in_stall_o = item_vld_q && !fire;
  assign accept     = in_valid_i && !in_stall_o;
  assign item_vld_d = accept || (item_vld_q && !fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else begin
      item_vld_q <= item_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.opcode        <= opcode_i;
      item_q.rx_char       <= rx_char_i;
      item_q.first_of_read <= first_of_read_i;
    end
  end

  cle_edit #(
    .RING_DEPTH (RING_DEPTH)
  ) u_edit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_q),
    .fire_i   (fire),
    .bundle_o (bundle)
  );

  cle_resq u_resq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .bundle_i    (bundle),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .head_o      (head),
    .free_o      (free)
  );

  // Result word on the ports
  assign kind_o           = head.kind;
  assign value_o          = head.value;
  assign erase_count_o    = head.erase_count;
  assign line_committed_o = head.line_committed;
  assign last_o           = head.last;

endmodule

/* rtl/cle_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// Read returns the old contents on a same-address write. No dependencies.
module cle_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/cle_edit.sv */
// Editing core: ring pointers, character ring and the decode of one word.
// Depends on cle_pkg and cle_ram.
module cle_edit #(
  parameter int unsigned RING_DEPTH = cle_pkg::RING_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cle_pkg::item_t       item_i,
  input  logic                 fire_i,
  output cle_pkg::res_bundle_t bundle_o
);

  localparam int unsigned ADDR_W = $clog2(RING_DEPTH);
  localparam int unsigned PTR_W  = $clog2(2 * RING_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(2 * RING_DEPTH - 1);
  localparam logic [PTR_W-1:0] DEPTH_P  = PTR_W'(RING_DEPTH);
  localparam logic [PTR_W:0]   MOD_X    = (PTR_W + 1)'(2 * RING_DEPTH);

  // Pointer arithmetic modulo twice the ring depth
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_LAST : p - 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dist(input logic [PTR_W-1:0] hi,
                                                input logic [PTR_W-1:0] lo);
    logic [PTR_W:0] d;
    d = {1'b0, hi} - {1'b0, lo};
    if (hi < lo) begin
      d = d + MOD_X;
    end
    return d[PTR_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] slot(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] s;
    s = (p >= DEPTH_P) ? p - DEPTH_P : p;
    return s[ADDR_W-1:0];
  endfunction

  function automatic cle_pkg::result_t mk(input cle_pkg::kind_e k,
                                          input logic [7:0] v,
                                          input logic [7:0] n,
                                          input logic c);
    cle_pkg::result_t r;
    r.kind           = k;
    r.value          = v;
    r.erase_count    = n;
    r.line_committed = c;
    r.last           = 1'b0;
    return r;
  endfunction

  logic [PTR_W-1:0]  rp_q, rp_d, rp_n;
  logic [PTR_W-1:0]  cp_q, cp_n;
  logic [PTR_W-1:0]  ep_q, ep_n;
  logic [PTR_W-1:0]  pending, used;
  logic [7:0]        ch_eff;
  logic              wr_en;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [7:0]        ram_rdata, ring_data;
  logic              byp_vld_q, byp_vld_d;
  logic [7:0]        byp_data_q;
  logic              commit;
  cle_pkg::res_bundle_t bundle;

  assign pending = ptr_dist(ep_q, cp_q);
  assign used    = ptr_dist(ep_q, rp_q);
  assign ch_eff  = (item_i.rx_char == cle_pkg::KEY_CR) ? cle_pkg::KEY_LF : item_i.rx_char;
  assign waddr   = slot(ep_q);

  // Decode of one word: results and next pointers
  always_comb begin
    rp_n   = rp_q;
    cp_n   = cp_q;
    ep_n   = ep_q;
    wr_en  = 1'b0;
    commit = 1'b0;
    bundle = '0;
    if (item_i.opcode == cle_pkg::OP_RX) begin
      if (item_i.rx_char == cle_pkg::KEY_CTRL_C) begin
        bundle.res[0] = mk(cle_pkg::KIND_ECHO, cle_pkg::KEY_CARET, 8'd0, 1'b0);
        bundle.res[1] = mk(cle_pkg::KIND_ECHO, cle_pkg::KEY_UPPER_C, 8'd0, 1'b0);
        bundle.res[2] = mk(cle_pkg::KIND_ECHO, cle_pkg::KEY_LF, 8'd0, 1'b0);
        bundle.cnt    = cle_pkg::CNT_W'(3);
        if (pending != '0) begin
          bundle.res[3] = mk(cle_pkg::KIND_ERASE, 8'd0, 8'(pending), 1'b0);
          bundle.cnt    = cle_pkg::CNT_W'(4);
          ep_n          = cp_q;
        end
      end else if (item_i.rx_char == cle_pkg::KEY_CTRL_U) begin
        if (pending != '0) begin
          bundle.res[0] = mk(cle_pkg::KIND_ERASE, 8'd0, 8'(pending), 1'b0);
          bundle.cnt    = cle_pkg::CNT_W'(1);
          ep_n          = cp_q;
        end
      end else if (item_i.rx_char == cle_pkg::KEY_CTRL_H ||
                   item_i.rx_char == cle_pkg::KEY_DEL) begin
        if (pending != '0) begin
          bundle.res[0] = mk(cle_pkg::KIND_ERASE, 8'd0, 8'd1, 1'b0);
          bundle.cnt    = cle_pkg::CNT_W'(1);
          ep_n          = ptr_dec(ep_q);
        end
      end else if (item_i.rx_char != cle_pkg::KEY_NUL && used < DEPTH_P) begin
        // store, echo, and commit on LF, Ctrl-D or a ring that becomes full
        wr_en  = 1'b1;
        ep_n   = ptr_inc(ep_q);
        commit = (ch_eff == cle_pkg::KEY_LF) || (ch_eff == cle_pkg::KEY_CTRL_D) ||
                 (used == DEPTH_P - 1'b1);
        if (commit) begin
          cp_n = ptr_inc(ep_q);
        end
        bundle.res[0] = mk(cle_pkg::KIND_ECHO, ch_eff, 8'd0, commit);
        bundle.cnt    = cle_pkg::CNT_W'(1);
      end
    end else begin
      bundle.cnt = cle_pkg::CNT_W'(1);
      if (rp_q == cp_q) begin
        bundle.res[0] = mk(cle_pkg::KIND_EMPTY, 8'd0, 8'd0, 1'b0);
      end else if (ring_data == cle_pkg::KEY_CTRL_D) begin
        if (item_i.first_of_read) begin
          rp_n          = ptr_inc(rp_q);
          bundle.res[0] = mk(cle_pkg::KIND_EOF, 8'd0, 8'd0, 1'b0);
        end else begin
          bundle.res[0] = mk(cle_pkg::KIND_EOF_STOP, 8'd0, 8'd0, 1'b0);
        end
      end else begin
        rp_n          = ptr_inc(rp_q);
        bundle.res[0] = mk(cle_pkg::KIND_READ, ring_data, 8'd0, 1'b0);
      end
    end
    // mark the final result of this word
    for (int i = 0; i < cle_pkg::MAX_RES; i++) begin
      if (cle_pkg::CNT_W'(i + 1) == bundle.cnt) begin
        bundle.res[i].last = 1'b1;
      end
    end
  end

  assign bundle_o = bundle;

  // Pointer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q <= '0;
      cp_q <= '0;
      ep_q <= '0;
    end else if (fire_i) begin
      rp_q <= rp_n;
      cp_q <= cp_n;
      ep_q <= ep_n;
    end
  end

  // Ring read always tracks the next read pointer; bypass a same-slot write
  assign rp_d      = fire_i ? rp_n : rp_q;
  assign raddr     = slot(rp_d);
  assign byp_vld_d = fire_i && wr_en && (waddr == raddr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_vld_q <= 1'b0;
    end else begin
      byp_vld_q <= byp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= ch_eff;
  end

  assign ring_data = byp_vld_q ? byp_data_q : ram_rdata;

  cle_ram #(
    .WIDTH (8),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (fire_i && wr_en),
    .waddr_i (waddr),
    .wdata_i (ch_eff),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

endmodule

/* rtl/cle_resq.sv */
// Result queue: holds a word's results; one out per cycle unless stalled.
// Depends on cle_pkg.
module cle_resq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  cle_pkg::res_bundle_t bundle_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output cle_pkg::result_t     head_o,
  output logic                 free_o
);

  cle_pkg::result_t [cle_pkg::MAX_RES-1:0] ent_q, ent_d;
  logic [cle_pkg::CNT_W-1:0]               cnt_q, cnt_d;
  logic                                    pop;

  assign pop    = (cnt_q != '0) && !out_stall_i;
  assign free_o = (cnt_q == '0) || ((cnt_q == cle_pkg::CNT_W'(1)) && !out_stall_i);

  // Load a new set of results or shift the head out
  always_comb begin
    ent_d = ent_q;
    cnt_d = cnt_q;
    if (load_i) begin
      ent_d = bundle_i.res;
      cnt_d = bundle_i.cnt;
    end else if (pop) begin
      for (int i = 0; i < cle_pkg::MAX_RES - 1; i++) begin
        ent_d[i] = ent_q[i + 1];
      end
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign out_valid_o = (cnt_q != '0);
  assign head_o      = ent_q[0];

endmodule

/* rtl/cle_checker.sv */
// Port-level checks of the console line editor, attached by bind.
// Depends on cle_pkg and the console_line_editor ports.
module cle_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       opcode_i,
  input logic [7:0] rx_char_i,
  input logic       first_of_read_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] kind_o,
  input logic [7:0] value_o,
  input logic [7:0] erase_count_o,
  input logic       line_committed_o,
  input logic       last_o
);

  // A stalled input word stays offered with its payload unchanged
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(opcode_i) && $stable(rx_char_i)
      && $stable(first_of_read_i))
    else $error("input word changed under stall");

  // A stalled result word stays and holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) && $stable(value_o)
      && $stable(erase_count_o) && $stable(line_committed_o) && $stable(last_o))
    else $error("result word changed under stall");

  // All results of a word are queued together: no gap before the last one
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o)
    else $error("result run broken before its last word");

  // Only an echo can carry the commit flag
  a_commit_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_committed_o |-> kind_o == cle_pkg::KIND_ECHO)
    else $error("commit flag on a non-echo result");

  // Value and count are zero for kinds that do not use them
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == cle_pkg::KIND_ERASE || kind_o == cle_pkg::KIND_EMPTY ||
      kind_o == cle_pkg::KIND_EOF || kind_o == cle_pkg::KIND_EOF_STOP ||
      kind_o == cle_pkg::KIND_ECHO || kind_o == cle_pkg::KIND_READ)
    |-> (kind_o == cle_pkg::KIND_ERASE || erase_count_o == 8'd0) &&
        (kind_o == cle_pkg::KIND_ECHO || kind_o == cle_pkg::KIND_READ || value_o == 8'd0))
    else $error("unused result field not zero");

endmodule

bind console_line_editor cle_checker u_cle_checker (.*);

/* tb/testbench.sv */
// Self-checking bench for console_line_editor: a directed table, a full-ring
// fill with a long output hold-off, then random line edits and read calls.
// Depends on rtl/cle_pkg.sv and rtl/console_line_editor.sv.
`timescale 1ns / 100ps

module testbench;
  import cle_pkg::*;

  localparam int unsigned RING  = RING_DEPTH_DEF;
  localparam int unsigned PTR_W = $clog2(RING) + 1;

  // One row of the directed table; typed rows carry their single expected word
  typedef struct packed {
    logic       op;
    logic [7:0] ch;
    logic       first;
    logic       typed;
    kind_e      kind;
    logic [7:0] value;
    logic [7:0] cnt;
    logic       cm;
  } dir_row_t;

  localparam int unsigned DIR_ROWS = 24;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic       opcode_i;
  logic [7:0] rx_char_i;
  logic       first_of_read_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [2:0] kind_o;
  logic [7:0] value_o;
  logic [7:0] erase_count_o;
  logic       line_committed_o;
  logic       last_o;

  // Editor state as seen by the bench
  logic [7:0]       line_mem [RING];
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] cm_ptr;
  logic [PTR_W-1:0] ed_ptr;

  // Words caused by the last accepted input, and the words still owed by the block
  result_t step_out [MAX_RES];
  int      step_n;
  result_t pending_console_out [$];

  int mismatch_count = 0;
  int live_words     = 0;
  int hold_req       = 0;
  bit steady         = 1'b0;

  dir_row_t dir_table [DIR_ROWS] = '{
    '{OP_READ, KEY_NUL,    1'b1, 1'b1, KIND_EMPTY,    8'h00,  8'd0, 1'b0},
    '{OP_READ, 8'hff,      1'b0, 1'b1, KIND_EMPTY,    8'h00,  8'd0, 1'b0},
    '{OP_RX,   KEY_NUL,    1'b0, 1'b0, KIND_ECHO,     8'h00,  8'd0, 1'b0},
    '{OP_RX,   KEY_CTRL_U, 1'b1, 1'b0, KIND_ECHO,     8'h00,  8'd0, 1'b0},
    '{OP_RX,   KEY_CTRL_H, 1'b0, 1'b0, KIND_ECHO,     8'h00,  8'd0, 1'b0},
    '{OP_RX,   KEY_DEL,    1'b0, 1'b0, KIND_ECHO,     8'h00,  8'd0, 1'b0},
    '{OP_RX,   8'hff,      1'b0, 1'b1, KIND_ECHO,     8'hff,  8'd0, 1'b0},
    '{OP_RX,   8'h61,      1'b0, 1'b0, KIND_ECHO,     8'h00,  8'd0, 1'b0},
    '{OP_RX,   KEY_CTRL_H, 1'b0, 1'b1, KIND_ERASE,    8'h00,  8'd1, 1'b0},
    '{OP_RX,   8'h80,      1'b1, 1'b0, KIND_ECHO,     8'h00,  8'd0, 1'b0},
    '{OP_RX,   KEY_CTRL_U, 1'b0, 1'b1, KIND_ERASE,    8'h00,  8'd2, 1'b0},
    '{OP_RX,   8'h78,      1'b0, 1'b0, KIND_ECHO,     8'h00,  8'd0, 1'b0},
    '{OP_RX,   KEY_CTRL_C, 1'b0, 1'b0, KIND_ECHO,     8'h00,  8'd0, 1'b0},
    '{OP_RX,   KEY_CTRL_C, 1'b0, 1'b0, KIND_ECHO,     8'h00,  8'd0, 1'b0},
    '{OP_RX,   8'h68,      1'b0, 1'b0, KIND_ECHO,     8'h00,  8'd0, 1'b0},
    '{OP_RX,   KEY_DEL,    1'b0, 1'b1, KIND_ERASE,    8'h00,  8'd1, 1'b0},
    '{OP_RX,   8'h69,      1'b0, 1'b0, KIND_ECHO,     8'h00,  8'd0, 1'b0},
    '{OP_RX,   KEY_CR,     1'b0, 1'b1, KIND_ECHO,     KEY_LF, 8'd0, 1'b1},
    '{OP_RX,   KEY_CTRL_D, 1'b0, 1'b1, KIND_ECHO,     KEY_CTRL_D, 8'd0, 1'b1},
    '{OP_READ, 8'h00,      1'b1, 1'b0, KIND_ECHO,     8'h00,  8'd0, 1'b0},
    '{OP_READ, 8'h00,      1'b0, 1'b0, KIND_ECHO,     8'h00,  8'd0, 1'b0},
    '{OP_READ, 8'h00,      1'b0, 1'b1, KIND_EOF_STOP, 8'h00,  8'd0, 1'b0},
    '{OP_READ, 8'h00,      1'b1, 1'b1, KIND_EOF,      8'h00,  8'd0, 1'b0},
    '{OP_READ, 8'h00,      1'b1, 1'b1, KIND_EMPTY,    8'h00,  8'd0, 1'b0}
  };

  console_line_editor dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .opcode_i        (opcode_i),
    .rx_char_i       (rx_char_i),
    .first_of_read_i (first_of_read_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .value_o         (value_o),
    .erase_count_o   (erase_count_o),
    .line_committed_o(line_committed_o),
    .last_o          (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 40) $display("%0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want)
      flag_mismatch($sformatf("%s: got %02h, want %02h", name, got, want));
  endtask

  function automatic void add_word(input kind_e k, input logic [7:0] v,
                                   input logic [7:0] n, input logic cm);
    step_out[step_n] = '{kind: k, value: v, erase_count: n,
                         line_committed: cm, last: 1'b0};
    step_n++;
  endfunction

  // Editor behavior for one input word; fills step_out and updates the pointers
  function automatic void console_step(input logic op, input logic [7:0] ch,
                                       input logic first);
    logic [PTR_W-1:0] pend;
    logic [PTR_W-1:0] fill;
    logic [7:0]       c;
    logic             cm;
    step_n = 0;
    pend = ed_ptr - cm_ptr;
    fill = ed_ptr - rd_ptr;
    if (op == OP_RX) begin
      if (ch == KEY_CTRL_C || ch == KEY_CTRL_U) begin
        if (ch == KEY_CTRL_C) begin
          add_word(KIND_ECHO, KEY_CARET, 8'd0, 1'b0);
          add_word(KIND_ECHO, KEY_UPPER_C, 8'd0, 1'b0);
          add_word(KIND_ECHO, KEY_LF, 8'd0, 1'b0);
        end
        if (pend != '0) begin
          add_word(KIND_ERASE, 8'h00, 8'(pend), 1'b0);
          ed_ptr = cm_ptr;
        end
      end else if (ch == KEY_CTRL_H || ch == KEY_DEL) begin
        if (pend != '0) begin
          ed_ptr = ed_ptr - 1'b1;
          add_word(KIND_ERASE, 8'h00, 8'd1, 1'b0);
        end
      end else if (ch != KEY_NUL && 32'(fill) < RING) begin
        // CR is stored and echoed as LF
        c = (ch == KEY_CR) ? KEY_LF : ch;
        line_mem[ed_ptr[PTR_W-2:0]] = c;
        ed_ptr = ed_ptr + 1'b1;
        fill = ed_ptr - rd_ptr;
        cm = (c == KEY_LF) || (c == KEY_CTRL_D) || (32'(fill) == RING);
        if (cm) cm_ptr = ed_ptr;
        add_word(KIND_ECHO, c, 8'd0, cm);
      end
    end else if (rd_ptr == cm_ptr) begin
      add_word(KIND_EMPTY, 8'h00, 8'd0, 1'b0);
    end else begin
      c = line_mem[rd_ptr[PTR_W-2:0]];
      if (c == KEY_CTRL_D) begin
        // end of file is consumed only at the start of a read call
        if (first) begin
          rd_ptr = rd_ptr + 1'b1;
          add_word(KIND_EOF, 8'h00, 8'd0, 1'b0);
        end else begin
          add_word(KIND_EOF_STOP, 8'h00, 8'd0, 1'b0);
        end
      end else begin
        rd_ptr = rd_ptr + 1'b1;
        add_word(KIND_READ, c, 8'd0, 1'b0);
      end
    end
    if (step_n > 0) step_out[step_n-1].last = 1'b1;
  endfunction

  // Ordinary byte: nonzero and not an editing or line-ending key
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (c == KEY_CTRL_C || c == KEY_CTRL_D || c == KEY_CTRL_H || c == KEY_LF ||
           c == KEY_CR || c == KEY_CTRL_U || c == KEY_DEL);
    return c;
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one word, wait for it to be taken, then queue what it should cause
  task automatic send_word(input logic op, input logic [7:0] ch, input logic first,
                           input bit typed, input result_t typed_word);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    opcode_i        <= op;
    rx_char_i       <= ch;
    first_of_read_i <= first;
    do @(posedge clk_i); while (in_stall_o);
    console_step(op, ch, first);
    if (step_n > 0) live_words++;
    if (typed) begin
      pending_console_out.push_back(typed_word);
    end else begin
      for (int i = 0; i < step_n; i++) pending_console_out.push_back(step_out[i]);
    end
  endtask

  // Output side: random stalls, plus a long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req > 0) begin
        stall_left = hold_req;
        hold_req   = 0;
      end
      if (stall_left == 0 && !steady && $urandom_range(0, 99) < 15)
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                 : $urandom_range(1, 3);
      out_stall_i <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // Compare each taken output word with the oldest one owed
  always @(posedge clk_i) begin : watch_out
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_console_out.size() == 0) begin
        flag_mismatch($sformatf("unexpected word kind %0d value %02h", kind_o, value_o));
      end else begin
        want = pending_console_out.pop_front();
        check_field("kind", 8'(kind_o), 8'(want.kind));
        check_field("value", value_o, want.value);
        check_field("erase_count", erase_count_o, want.erase_count);
        check_field("line_committed", 8'(line_committed_o), 8'(want.line_committed));
        check_field("last", 8'(last_o), 8'(want.last));
      end
    end
  end

  // Hard stop in case the block hangs
  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int      len;
    int      r;
    int      target;
    logic [7:0] ch;
    result_t row_word;

    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    opcode_i        <= OP_RX;
    rx_char_i       <= KEY_NUL;
    first_of_read_i <= 1'b0;
    rd_ptr = '0;
    cm_ptr = '0;
    ed_ptr = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    foreach (dir_table[i]) begin
      row_word = '{kind: dir_table[i].kind, value: dir_table[i].value,
                   erase_count: dir_table[i].cnt, line_committed: dir_table[i].cm,
                   last: 1'b1};
      send_word(dir_table[i].op, dir_table[i].ch, dir_table[i].first,
                dir_table[i].typed, row_word);
    end

    // Fill the ring while the output is held off, so the block backs up
    steady   = 1'b1;
    hold_req = 200;
    repeat (RING + 3) send_word(OP_RX, plain_char(), 1'($urandom), 1'b0, '0);
    send_word(OP_RX, KEY_CTRL_D, 1'b0, 1'b0, '0);
    send_word(OP_RX, KEY_CTRL_H, 1'b0, 1'b0, '0);
    send_word(OP_RX, KEY_CTRL_C, 1'b0, 1'b0, '0);
    steady = 1'b0;
    repeat (RING + 2) send_word(OP_READ, 8'($urandom), 1'($urandom), 1'b0, '0);

    // Random lines with edits and read calls, plus some noise
    target = live_words + 16;
    while (live_words < target) begin
      steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 3) != 0) begin
        len = $urandom_range(0, 10);
        for (int k = 0; k < len; k++) begin
          r = $urandom_range(0, 99);
          if (r < 8)       ch = $urandom_range(0, 1) ? KEY_CTRL_H : KEY_DEL;
          else if (r < 11) ch = KEY_CTRL_U;
          else             ch = plain_char();
          send_word(OP_RX, ch, 1'($urandom), 1'b0, '0);
        end
        r = $urandom_range(0, 99);
        if (r < 45)      ch = KEY_LF;
        else if (r < 75) ch = KEY_CR;
        else if (r < 93) ch = KEY_CTRL_D;
        else             ch = KEY_CTRL_C;
        send_word(OP_RX, ch, 1'($urandom), 1'b0, '0);
        if ($urandom_range(0, 9) < 7) begin
          r = $urandom_range(1, len + 3);
          for (int k = 0; k < r; k++)
            send_word(OP_READ, 8'($urandom), k == 0, 1'b0, '0);
        end
      end else begin
        repeat ($urandom_range(1, 6))
          send_word(1'($urandom), 8'($urandom), 1'($urandom), 1'b0, '0);
      end
    end
    steady = 1'b0;

    // Drain
    in_valid_i <= 1'b0;
    while (pending_console_out.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/cle_pkg.sv
rtl/cle_ram.sv
rtl/cle_edit.sv
rtl/cle_resq.sv
rtl/console_line_editor.sv
rtl/cle_checker.sv
tb/testbench.sv
